/* rtl/mdbs_pkg.sv */
// Shared types, constants and the brightness table for the debounced brightness stepper.
package mdbs_pkg;

    localparam int unsigned TableEntriesDef = 10;
    localparam int unsigned TableMax        = 16;

    localparam logic [7:0] SAMPLES_RESET    = 8'd30;
    localparam logic [3:0] STEP_INDEX_RESET = 4'd4;
    localparam logic [7:0] DUTY_RESET       = 8'd125;

    typedef enum logic {
        OP_PIN_CHANGE = 1'b0,
        OP_TICK       = 1'b1
    } t_opcode;

    typedef struct packed {
        t_opcode opcode;
        logic    button_level;
    } t_item;

    typedef struct packed {
        logic       stepped;
        logic       sampling;
        logic [3:0] level_index;
        logic [7:0] duty;
    } t_result;

    // Logarithmic duty steps; entries past the tenth saturate at full scale.
    localparam logic [7:0] DUTY_TABLE [TableMax] = '{
        8'd0,   8'd11,  8'd24,  8'd39,  8'd56,  8'd76,  8'd101, 8'd133,
        8'd178, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255
    };

    function automatic logic [7:0] duty_lookup(input logic [3:0] idx);
        return DUTY_TABLE[idx];
    endfunction

endpackage

/* rtl/mdbs_core.sv */
// Voting window state and brightness step update for one registered beat.
module mdbs_core #(
    parameter int unsigned TABLE_ENTRIES = mdbs_pkg::TableEntriesDef
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  mdbs_pkg::t_item     i_item,
    input  logic [7:0]          i_samples,
    output mdbs_pkg::t_result   o_result
);

    logic       r_window_open, n_window_open;
    logic [7:0] r_tick_count,  n_tick_count;
    logic [7:0] r_low_count,   n_low_count;
    logic [7:0] r_high_count,  n_high_count;
    logic [3:0] r_step_index,  n_step_index;
    logic [7:0] r_duty,        n_duty;
    logic       n_stepped;

    logic       pressed;
    logic [7:0] limit;
    logic [8:0] ticks;
    logic [7:0] low_inc;
    logic [7:0] high_inc;
    logic [4:0] next_index;

    always_comb begin
        pressed    = ~i_item.button_level;
        limit      = (i_samples == 8'd0) ? 8'd1 : i_samples;
        ticks      = {1'b0, r_tick_count} + 9'd1;
        low_inc    = pressed ? r_low_count + 8'd1 : r_low_count;
        high_inc   = pressed ? r_high_count : r_high_count + 8'd1;
        next_index = {1'b0, r_step_index} + 5'd1;
        if (next_index >= 5'(TABLE_ENTRIES)) begin
            next_index = 5'd0;
        end

        n_window_open = r_window_open;
        n_tick_count  = r_tick_count;
        n_low_count   = r_low_count;
        n_high_count  = r_high_count;
        n_step_index  = r_step_index;
        n_duty        = r_duty;
        n_stepped     = 1'b0;

        case (i_item.opcode)
            mdbs_pkg::OP_PIN_CHANGE: begin
                if (!r_window_open && pressed) begin
                    n_window_open = 1'b1;
                    n_tick_count  = 8'd0;
                    n_low_count   = 8'd0;
                    n_high_count  = 8'd0;
                end
            end
            mdbs_pkg::OP_TICK: begin
                if (r_window_open) begin
                    n_tick_count = ticks[7:0];
                    n_low_count  = low_inc;
                    n_high_count = high_inc;
                    // The window closes once the count reaches the limit, which
                    // also covers a limit lowered while the window was open.
                    if (ticks >= {1'b0, limit}) begin
                        if (low_inc >= high_inc) begin
                            n_step_index = next_index[3:0];
                            n_duty       = mdbs_pkg::duty_lookup(next_index[3:0]);
                            n_stepped    = 1'b1;
                        end
                        n_window_open = 1'b0;
                        n_tick_count  = 8'd0;
                        n_low_count   = 8'd0;
                        n_high_count  = 8'd0;
                    end
                end
            end
            default: begin
            end
        endcase

        o_result.duty        = n_duty;
        o_result.level_index = n_step_index;
        o_result.sampling    = n_window_open;
        o_result.stepped     = n_stepped;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_open <= 1'b0;
            r_tick_count  <= 8'd0;
            r_low_count   <= 8'd0;
            r_high_count  <= 8'd0;
            r_step_index  <= mdbs_pkg::STEP_INDEX_RESET;
            r_duty        <= mdbs_pkg::DUTY_RESET;
        end else if (i_en) begin
            r_window_open <= n_window_open;
            r_tick_count  <= n_tick_count;
            r_low_count   <= n_low_count;
            r_high_count  <= n_high_count;
            r_step_index  <= n_step_index;
            r_duty        <= n_duty;
        end
    end

endmodule

/* rtl/majority_debounced_brightness_stepper.sv */
// Top level of the majority-vote debounced brightness stepper.
// Each input beat is an event (tuser bit 0: 0 = pin change, 1 = sample tick) with the
// button level in tdata bit 0 (0 = pressed), and each produces exactly one output beat
// carrying the duty, table index, window-open flag and a stepped flag after the update.
// The block takes one beat per clock cycle unless the output stalls: the beat is
// captured in an input register, the state update is one short stage of counters and a
// compare, and the result sits in an output register; an empty input register still
// takes a beat while the output waits. The window length register may be written at
// any time on the config channel, but should only change while no beats are in flight.
module majority_debounced_brightness_stepper #(
    parameter int unsigned TABLE_ENTRIES = mdbs_pkg::TableEntriesDef
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [0] button_level, [7:1] zero
    input  logic        s_axis_tuser,   // [0] opcode
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [7:0] duty, [11:8] level_index, [12] sampling,
                                        // [13] stepped, [15:14] zero
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_data
);

    logic              r_in_valid;
    mdbs_pkg::t_item   r_in_item;
    logic              r_out_valid;
    mdbs_pkg::t_result r_out_result;
    mdbs_pkg::t_result core_result;
    logic [7:0]        r_samples;
    logic              adv_out;

    assign adv_out       = !r_out_valid || m_axis_tready;
    assign s_axis_tready = !r_in_valid || adv_out;
    assign o_cfg_ready   = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_samples <= mdbs_pkg::SAMPLES_RESET;
        end else if (i_cfg_valid) begin
            r_samples <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_item.opcode       <= mdbs_pkg::t_opcode'(s_axis_tuser);
            r_in_item.button_level <= s_axis_tdata[0];
        end
    end

    mdbs_core #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (r_in_valid && adv_out),
        .i_item    (r_in_item),
        .i_samples (r_samples),
        .o_result  (core_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv_out) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv_out && r_in_valid) begin
            r_out_result <= core_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {2'b00, r_out_result};

endmodule

/* rtl/mdbs_checker.sv */
// Port-level checks for the debounced brightness stepper, bound to its top level.
module mdbs_checker #(
    parameter int unsigned TABLE_ENTRIES = mdbs_pkg::TableEntriesDef
) (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata
);

    // A step always closes the window.
    a_step_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata[13]) |-> !m_axis_tdata[12])
        else $error("stepped beat shows an open window");

    // A step loads the duty from the table at the new index.
    a_step_duty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata[13]) |->
            (m_axis_tdata[7:0] == mdbs_pkg::duty_lookup(m_axis_tdata[11:8])))
        else $error("stepped duty does not match the table");

    // The index stays inside the table unless it still holds its reset value.
    a_index_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |->
            (({1'b0, m_axis_tdata[11:8]} < 5'(TABLE_ENTRIES))
             || (m_axis_tdata[11:8] == mdbs_pkg::STEP_INDEX_RESET)))
        else $error("level index outside the table");

    // A stalled output beat holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("output beat changed while stalled");

endmodule

bind majority_debounced_brightness_stepper mdbs_checker #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
) u_mdbs_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
